FILE: rtl/core/mme_pkg.sv
// Shared types, codes and microcode table of the matrix multiply engine.
`default_nettype none
package mme_pkg;

  // Fixed field widths.
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 3;
  localparam int DIM_REG_W   = 4;
  localparam int SUM_W       = 36;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_PAD_W   = OUT_DATA_W - 2 * IDX_W - SUM_W;

  // Commands carried in the input tuser.
  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  // Microprogram steps.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_INIT = 3'd1;
  localparam logic [STEP_W-1:0] STEP_READ = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MUL  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ACC  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EMIT = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NEXT = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DONE = 3'd7;

  // Jump conditions.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_NONE      = 3'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd1;
  localparam logic [COND_W-1:0] COND_NOT_START = 3'd2;
  localparam logic [COND_W-1:0] COND_N_ZERO    = 3'd3;
  localparam logic [COND_W-1:0] COND_P_MORE    = 3'd4;
  localparam logic [COND_W-1:0] COND_OUT_BUSY  = 3'd5;
  localparam logic [COND_W-1:0] COND_NOT_LAST  = 3'd6;

  // Datapath controls driven by one microcode word.
  typedef struct packed {
    logic in_ready;
    logic clr_acc;
    logic rd_en;
    logic mul_en;
    logic acc_en;
    logic emit;
    logic adv;
  } ctrl_t;

  // Datapath status used for jumps.
  typedef struct packed {
    logic start;
    logic n_zero;
    logic p_more;
    logic out_busy;
    logic not_last;
  } status_t;

  typedef struct packed {
    ctrl_t              ctrl;
    logic [COND_W-1:0]  cond;
    logic [STEP_W-1:0]  target;
  } ucode_t;

  // Control store: a jump goes to target, otherwise fall through to the next step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.ctrl.in_ready = 1'b1;
        w.cond          = COND_NOT_START;
        w.target        = STEP_IDLE;
      end
      STEP_INIT: begin
        w.ctrl.clr_acc = 1'b1;
        w.cond         = COND_N_ZERO;
        w.target       = STEP_EMIT;
      end
      STEP_READ: begin
        w.ctrl.rd_en = 1'b1;
        w.cond       = COND_NONE;
      end
      STEP_MUL: begin
        w.ctrl.mul_en = 1'b1;
        w.cond        = COND_NONE;
      end
      STEP_ACC: begin
        w.ctrl.acc_en = 1'b1;
        w.cond        = COND_P_MORE;
        w.target      = STEP_READ;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = COND_OUT_BUSY;
        w.target    = STEP_EMIT;
      end
      STEP_NEXT: begin
        w.ctrl.adv = 1'b1;
        w.cond     = COND_NOT_LAST;
        w.target   = STEP_INIT;
      end
      STEP_DONE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mme_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none
module mme_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  mme_pkg::status_t status,
  output mme_pkg::ctrl_t   ctrl
);
  import mme_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            word;
  logic              jump;

  assign word = ucode_rom(step);
  assign ctrl = word.ctrl;

  always_comb begin
    unique case (word.cond)
      COND_NONE:      jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NOT_START: jump = ~status.start;
      COND_N_ZERO:    jump = status.n_zero;
      COND_P_MORE:    jump = status.p_more;
      COND_OUT_BUSY:  jump = status.out_busy;
      COND_NOT_LAST:  jump = status.not_last;
      default:        jump = 1'b1;
    endcase
    step_next = jump ? word.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mme_datapath.sv
// Datapath: element stores, index counters, multiplier, accumulator, result register.
`default_nettype none
module mme_datapath #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  localparam int DIMV_W = ($clog2(MAX_DIM + 1) > mme_pkg::DIM_REG_W) ?
                          $clog2(MAX_DIM + 1) : mme_pkg::DIM_REG_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mme_pkg::ctrl_t                ctrl,
  output mme_pkg::status_t              status,
  input  logic                          in_fire,
  input  logic [mme_pkg::CMD_W-1:0]     cmd,
  input  logic [mme_pkg::IDX_W-1:0]     row,
  input  logic [mme_pkg::IDX_W-1:0]     col,
  input  logic [ELEM_WIDTH-1:0]         value,
  input  logic [DIMV_W-1:0]             m_dim,
  input  logic [DIMV_W-1:0]             n_dim,
  input  logic [DIMV_W-1:0]             k_dim,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mme_pkg::IDX_W-1:0]     out_row,
  output logic [mme_pkg::IDX_W-1:0]     out_col,
  output logic [mme_pkg::SUM_W-1:0]     out_value,
  output logic                          out_last
);
  import mme_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int EXT_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

  logic [CNT_W-1:0]       i_cnt;
  logic [CNT_W-1:0]       j_cnt;
  logic [CNT_W-1:0]       p_cnt;
  logic [DIMV_W-1:0]      i_ext;
  logic [DIMV_W-1:0]      j_ext;
  logic [DIMV_W-1:0]      p_ext;
  logic                   last_i;
  logic                   last_j;
  logic                   wr_ok;
  logic                   we_a;
  logic                   we_b;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr_a;
  logic [ADDR_W-1:0]      raddr_b;
  logic [ELEM_WIDTH-1:0]  rdata_a;
  logic [ELEM_WIDTH-1:0]  rdata_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [EXT_W-1:0]  prod_ext;
  logic [SUM_W-1:0]       acc;
  logic                   emit_fire;

  assign i_ext  = DIMV_W'(i_cnt);
  assign j_ext  = DIMV_W'(j_cnt);
  assign p_ext  = DIMV_W'(p_cnt);
  assign last_i = (i_ext == m_dim - DIMV_W'(1));
  assign last_j = (j_ext == k_dim - DIMV_W'(1));

  // Writes outside the store are dropped; inside the store they land whatever the dims.
  assign wr_ok = (DIMV_W'(row) < DIMV_W'(MAX_DIM)) && (DIMV_W'(col) < DIMV_W'(MAX_DIM));
  assign we_a  = in_fire && (cmd == CMD_WRITE_A) && wr_ok;
  assign we_b  = in_fire && (cmd == CMD_WRITE_B) && wr_ok;
  assign waddr = ADDR_W'(32'(row) * 32'(MAX_DIM) + 32'(col));

  assign raddr_a = ADDR_W'(32'(i_cnt) * 32'(MAX_DIM) + 32'(p_cnt));
  assign raddr_b = ADDR_W'(32'(p_cnt) * 32'(MAX_DIM) + 32'(j_cnt));

  assign status.start    = in_fire && (cmd == CMD_COMPUTE) &&
                           (m_dim != '0) && (k_dim != '0);
  assign status.n_zero   = (n_dim == '0);
  assign status.p_more   = ((p_ext + DIMV_W'(1)) < n_dim);
  assign status.out_busy = out_valid && !out_ready;
  assign status.not_last = !(last_i && last_j);

  assign emit_fire = ctrl.emit && !status.out_busy;
  assign prod_ext  = EXT_W'(prod);

  mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (value),
    .re    (ctrl.rd_en),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (value),
    .re    (ctrl.rd_en),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Index counters walk C in row-major order.
  always_ff @(posedge clk) begin
    if (status.start) begin
      i_cnt <= '0;
      j_cnt <= '0;
    end else if (ctrl.adv) begin
      if (last_j) begin
        j_cnt <= '0;
        i_cnt <= i_cnt + CNT_W'(1);
      end else begin
        j_cnt <= j_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= $signed(rdata_a) * $signed(rdata_b);
    end
    if (ctrl.clr_acc) begin
      acc   <= '0;
      p_cnt <= '0;
    end else if (ctrl.acc_en) begin
      acc   <= acc + prod_ext[SUM_W-1:0];
      p_cnt <= p_cnt + CNT_W'(1);
    end
  end

  // Result register: hold until taken, refill in the same cycle it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_row   <= i_ext[IDX_W-1:0];
      out_col   <= j_ext[IDX_W-1:0];
      out_value <= acc;
      out_last  <= last_i && last_j;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: ports, configuration registers, core wiring.
`default_nettype none
// Matrix multiply engine, C = A x B on signed fixed-point elements (Q1.15 at the
// default width) with exact Q6.30 sums, wrapping modulo 2^36 only if the
// parameters are raised far enough to overflow. Each request on the slave
// stream carries a command in s_tuser: write one element of A, write one element
// of B, or compute. A new request is taken every cycle while the engine is
// idle; a write whose row or column is MAX_DIM or more is dropped, and command 3
// is dropped. A compute request streams every element of C in row-major order
// on the master stream, with m_tlast on the final one; a rows_a or cols_b of
// zero yields no result, an inner_dim of zero yields zeros. Dimension registers
// above MAX_DIM act as MAX_DIM. Configuration is to be written only while the
// engine is idle; the user must keep to this, as the engine does not enforce it.
// A compute request holds s_tready low for the whole run plus any output stall,
// paced by the single shared multiplier-accumulator, which the microcode
// sequencer steps through read, multiply and accumulate steps per product behind
// the registered read of the two element RAMs. Results wait in an output register,
// so the engine returns to idle and takes new requests before the last one is
// taken. Elements never written read back as undefined.
module matrix_multiply_engine #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  localparam int IN_DATA_W = ((2 * mme_pkg::IDX_W + ELEM_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // Slave stream: load or compute requests.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata from bit 0: row_index[3], col_index[3], element_value[ELEM_WIDTH], zero pad
  input  logic [IN_DATA_W-1:0]            s_tdata,
  // s_tuser: command[2]
  input  logic [mme_pkg::CMD_W-1:0]       s_tuser,
  // Master stream: C elements.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata from bit 0: out_row[3], out_col[3], product_value[36], zero pad
  output logic [mme_pkg::OUT_DATA_W-1:0]  m_tdata,
  // m_tlast: last_flag
  output logic                            m_tlast,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mme_pkg::DIM_REG_W-1:0]   cfg_data
);
  import mme_pkg::*;

  localparam int DIMV_W = ($clog2(MAX_DIM + 1) > DIM_REG_W) ? $clog2(MAX_DIM + 1) : DIM_REG_W;

  logic [DIM_REG_W-1:0] rows_a;
  logic [DIM_REG_W-1:0] inner_dim;
  logic [DIM_REG_W-1:0] cols_b;
  logic [DIMV_W-1:0]    m_dim;
  logic [DIMV_W-1:0]    n_dim;
  logic [DIMV_W-1:0]    k_dim;
  ctrl_t                ctrl;
  status_t              status;
  logic                 in_fire;
  logic [IDX_W-1:0]     out_row;
  logic [IDX_W-1:0]     out_col;
  logic [SUM_W-1:0]     out_value;

  // Configuration registers; writes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_REG_W'(8);
      inner_dim <= DIM_REG_W'(8);
      cols_b    <= DIM_REG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a    <= cfg_data;
        CFG_INNER_DIM: inner_dim <= cfg_data;
        CFG_COLS_B:    cols_b    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clamp each dimension to the store size.
  always_comb begin
    m_dim = (DIMV_W'(rows_a) > DIMV_W'(MAX_DIM)) ? DIMV_W'(MAX_DIM) : DIMV_W'(rows_a);
    n_dim = (DIMV_W'(inner_dim) > DIMV_W'(MAX_DIM)) ? DIMV_W'(MAX_DIM) : DIMV_W'(inner_dim);
    k_dim = (DIMV_W'(cols_b) > DIMV_W'(MAX_DIM)) ? DIMV_W'(MAX_DIM) : DIMV_W'(cols_b);
  end

  // Requests are taken only in the idle step of the microprogram.
  assign s_tready = ctrl.in_ready;
  assign in_fire  = s_tvalid && s_tready;

  mme_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mme_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .in_fire   (in_fire),
    .cmd       (s_tuser),
    .row       (s_tdata[IDX_W-1:0]),
    .col       (s_tdata[2*IDX_W-1:IDX_W]),
    .value     (s_tdata[2*IDX_W+ELEM_WIDTH-1:2*IDX_W]),
    .m_dim     (m_dim),
    .n_dim     (n_dim),
    .k_dim     (k_dim),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_tlast)
  );

  // Pack the result; pad bits stay zero.
  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_value, out_col, out_row};

endmodule
`default_nettype wire

FILE: rtl/core/mme_checker.sv
// Port-level assertions for the matrix multiply engine and their bind.
`default_nettype none
module mme_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [mme_pkg::CMD_W-1:0]       s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mme_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tlast,
  input logic                            cfg_we,
  input logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [mme_pkg::DIM_REG_W-1:0]   cfg_data
);
  import mme_pkg::*;

  logic [DIM_REG_W-1:0] rows_seen;
  logic [DIM_REG_W-1:0] cols_seen;
  logic                 s_fire;

  assign s_fire = s_tvalid && s_tready;

  // Track the output dimensions from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_seen <= DIM_REG_W'(8);
      cols_seen <= DIM_REG_W'(8);
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROWS_A) begin
        rows_seen <= cfg_data;
      end
      if (cfg_index == CFG_COLS_B) begin
        cols_seen <= cfg_data;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_ready_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> s_tready)
    else $error("engine not idle after reset");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    s_fire && (s_tuser == CMD_COMPUTE) && (rows_seen != '0) && (cols_seen != '0)
    |=> !s_tready)
    else $error("compute request did not start a run");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking stream testbench for the matrix multiply engine.
`timescale 1ns / 1ps
module testbench;
  import mme_pkg::*;

  localparam int MAX_DIM      = 8;
  localparam int ELEM_W       = 16;
  localparam int IN_DATA_W    = ((2 * IDX_W + ELEM_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_DATA_W - 2 * IDX_W - ELEM_W;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_SETTLE  = 8;     // wait for the engine to step from last emit back to idle
  localparam int END_WAIT     = 32;
  localparam int LONG_HOLD    = 600;   // receiver hold-off that backs up the engine
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake or register write at all
  localparam int REPORT_MAX   = 10;

  // Codes the package leaves out: the spare command and the spare register slot.
  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] elem;
  } mme_req_t;

  // One element of C as it leaves the engine.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [SUM_W-1:0] dot;
    logic             last;
  } c_elem_t;

  // Directed stimulus row: either a register write or a request, the latter
  // optionally with a single C element whose value is known by inspection.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_REG_W-1:0] cfg_val;
    mme_req_t             req;
    logic                 known;
    logic [SUM_W-1:0]     known_dot;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata;   // from bit 0: row_index[3], col_index[3], element_value[16], pad
  logic [CMD_W-1:0]     s_tuser;   // command[2]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;  // from bit 0: out_row[3], out_col[3], product_value[36], pad
  logic                 m_tlast;   // last_flag
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_REG_W-1:0] cfg_data;

  // Shadow of the engine: dimension registers and both element stores.
  logic [DIM_REG_W-1:0]     rows_reg, inner_reg, cols_reg;
  logic signed [ELEM_W-1:0] a_store [MAX_DIM][MAX_DIM];
  logic signed [ELEM_W-1:0] b_store [MAX_DIM][MAX_DIM];
  bit                       a_written [MAX_DIM][MAX_DIM];
  bit                       b_written [MAX_DIM][MAX_DIM];

  c_elem_t     c_elem_queue [$];   // C elements still owed by the engine
  dir_row_t    directed_rows [$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  bit          valid_up;
  int unsigned hold_asked, hold_seen;

  matrix_multiply_engine dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register values above MAX_DIM behave as MAX_DIM.
  function automatic int unsigned eff_dim(logic [DIM_REG_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // Work out every element of C from the shadow stores, row-major.
  function automatic void predict_c_matrix();
    int unsigned m, n, k;
    logic signed [SUM_W-1:0] acc;
    c_elem_t e;
    m = eff_dim(rows_reg);
    n = eff_dim(inner_reg);
    k = eff_dim(cols_reg);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < k; j++) begin
        acc = '0;
        for (int p = 0; p < n; p++) acc = acc + a_store[i][p] * b_store[p][j];
        e.row  = IDX_W'(i);
        e.col  = IDX_W'(j);
        e.dot  = acc;
        e.last = (i == m - 1) && (j == k - 1);
        c_elem_queue.push_back(e);
      end
    end
  endfunction

  // Fold one accepted request into the shadow state.
  function automatic void predict_request(mme_req_t r);
    case (r.cmd)
      CMD_WRITE_A: begin
        a_store[r.row][r.col]   = r.elem;
        a_written[r.row][r.col] = 1'b1;
      end
      CMD_WRITE_B: begin
        b_store[r.row][r.col]   = r.elem;
        b_written[r.row][r.col] = 1'b1;
      end
      CMD_COMPUTE: predict_c_matrix();
      default: ;  // spare command: dropped by the engine
    endcase
  endfunction

  function automatic mme_req_t make_request(logic [CMD_W-1:0] cmd, int unsigned row,
                                            int unsigned col, logic [ELEM_W-1:0] elem);
    mme_req_t r;
    r.cmd  = cmd;
    r.row  = IDX_W'(row);
    r.col  = IDX_W'(col);
    r.elem = elem;
    return r;
  endfunction

  // Element values lean on the Q1.15 extremes.
  function automatic logic [ELEM_W-1:0] random_elem();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Mostly small sizes, now and then zero, the full size or above range.
  function automatic logic [DIM_REG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 4'd0;
      1:       return 4'd8;
      2:       return DIM_REG_W'($urandom_range(9, 15));
      default: return DIM_REG_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic void add_req(logic [CMD_W-1:0] cmd, int unsigned row, int unsigned col,
                                  logic [ELEM_W-1:0] elem, logic known,
                                  logic [SUM_W-1:0] known_dot);
    dir_row_t d;
    d           = '0;
    d.req       = make_request(cmd, row, col, elem);
    d.known     = known;
    d.known_dot = known_dot;
    directed_rows.push_back(d);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] val);
    dir_row_t d;
    d         = '0;
    d.is_cfg  = 1'b1;
    d.cfg_idx = idx;
    d.cfg_val = val;
    directed_rows.push_back(d);
  endfunction

  function automatic void report_mismatch(string what, c_elem_t want, c_elem_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("C %s: exp r%0d c%0d dot %0d last %0b, got r%0d c%0d dot %0d last %0b",
               what, want.row, want.col, $signed(want.dot), want.last,
               got.row, got.col, $signed(got.dot), got.last);
  endfunction

  // Offer one request and hold it until taken. The sender works in bursts:
  // valid stays up across a burst and drops for a random gap at its end.
  task automatic send_request(mme_req_t r, logic known, logic [SUM_W-1:0] known_dot);
    c_elem_t e;
    s_tvalid <= 1'b1;
    valid_up = 1'b1;
    s_tuser  <= r.cmd;
    s_tdata  <= {{IN_PAD_W{1'b0}}, r.elem, r.col, r.row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (known) begin
      e.row  = '0;
      e.col  = '0;
      e.dot  = known_dot;
      e.last = 1'b1;
      c_elem_queue.push_back(e);
    end else begin
      predict_request(r);
    end
    burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 12);
    end
  endtask

  // Drop valid, wait for every owed C element, then let the engine reach idle.
  task automatic settle();
    if (valid_up) begin
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
    while (c_elem_queue.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // One register write, with cfg_we dropped again before the next so writes never merge.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_ROWS_A:    rows_reg  = val;
      CFG_INNER_DIM: inner_reg = val;
      CFG_COLS_B:    cols_reg  = val;
      default: ;  // spare slot: no register behind it
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus: directed table first, then random phases of loads and computes.
  initial begin
    mme_req_t    r;
    dir_row_t    d;
    int unsigned m, n, k, random_items, phase, ri, rc;
    logic [DIM_REG_W-1:0] d_rows, d_inner, d_cols;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_WRITE_A;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ROWS_A;
    cfg_data  <= '0;
    rows_reg  = 4'd8;
    inner_reg = 4'd8;
    cols_reg  = 4'd8;
    mismatch_count = 0;
    burst_left     = 8;
    valid_up       = 1'b0;
    hold_asked     = 0;
    random_items   = 0;

    // 1x1x1 products at the corners of Q1.15.
    add_cfg(CFG_ROWS_A, 4'd1);
    add_cfg(CFG_INNER_DIM, 4'd1);
    add_cfg(CFG_COLS_B, 4'd1);
    add_req(CMD_WRITE_A, 0, 0, 16'h8000, 1'b0, '0);
    add_req(CMD_WRITE_B, 0, 0, 16'h8000, 1'b0, '0);
    add_req(CMD_COMPUTE, 0, 0, 16'h0000, 1'b1, 36'sd1073741824);
    add_req(CMD_WRITE_A, 0, 0, 16'h7FFF, 1'b0, '0);
    // Compute ignores its index and element fields; drive them all ones.
    add_req(CMD_COMPUTE, 7, 7, 16'hFFFF, 1'b1, -36'sd1073709056);
    add_req(CMD_WRITE_B, 0, 0, 16'h7FFF, 1'b0, '0);
    add_req(CMD_COMPUTE, 5, 2, 16'h1234, 1'b1, 36'sd1073676289);
    // Spare command is dropped; writes outside the current size still land.
    add_req(CMD_UNUSED, 7, 7, 16'hFFFF, 1'b0, '0);
    add_req(CMD_WRITE_A, 7, 7, 16'h5A5A, 1'b0, '0);
    add_req(CMD_WRITE_B, 7, 7, 16'hA5A5, 1'b0, '0);
    // Empty inner dimension gives zeros; no rows or no columns gives nothing.
    add_cfg(CFG_INNER_DIM, 4'd0);
    add_req(CMD_COMPUTE, 0, 0, 16'h0000, 1'b1, '0);
    add_cfg(CFG_ROWS_A, 4'd0);
    add_req(CMD_COMPUTE, 0, 0, 16'h0000, 1'b0, '0);
    add_cfg(CFG_ROWS_A, 4'd1);
    add_cfg(CFG_COLS_B, 4'd0);
    add_req(CMD_COMPUTE, 0, 0, 16'h0000, 1'b0, '0);
    add_cfg(CFG_UNUSED, 4'd15);
    // Rows above range act as the full size.
    add_cfg(CFG_ROWS_A, 4'd15);
    add_cfg(CFG_INNER_DIM, 4'd1);
    add_cfg(CFG_COLS_B, 4'd2);
    for (int i = 1; i < MAX_DIM; i++)
      add_req(CMD_WRITE_A, i, 0, i[0] ? 16'h8000 : 16'h7FFF, 1'b0, '0);
    add_req(CMD_WRITE_B, 0, 1, 16'h8000, 1'b0, '0);
    add_req(CMD_COMPUTE, 0, 0, 16'h0000, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      d = directed_rows[i];
      if (d.is_cfg) begin
        settle();
        write_cfg(d.cfg_idx, d.cfg_val);
      end else begin
        send_request(d.req, d.known, d.known_dot);
      end
    end

    // Random phases. The first two run the full size (reached both directly
    // and through above-range values), the third backs the engine up behind
    // a long receiver hold, later ones pick sizes at random.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin d_rows = 4'd8;  d_inner = 4'd8;  d_cols = 4'd8;  end
        1: begin d_rows = 4'd15; d_inner = 4'd15; d_cols = 4'd15; end
        2: begin d_rows = 4'd4;  d_inner = 4'd2;  d_cols = 4'd4;  end
        default: begin d_rows = pick_dim(); d_inner = pick_dim(); d_cols = pick_dim(); end
      endcase
      settle();
      write_cfg(CFG_ROWS_A, d_rows);
      write_cfg(CFG_INNER_DIM, d_inner);
      write_cfg(CFG_COLS_B, d_cols);
      if (phase == 2) hold_asked++;
      m = eff_dim(rows_reg);
      n = eff_dim(inner_reg);
      k = eff_dim(cols_reg);

      // Under the long hold, keep offering requests behind the first compute.
      repeat ((phase == 2) ? 2 : $urandom_range(1, 3)) begin
        // Noise: stray loads anywhere and the odd spare command.
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 9) == 0)
            r = make_request(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                             random_elem());
          else
            r = make_request($urandom_range(0, 1) ? CMD_WRITE_A : CMD_WRITE_B,
                             $urandom_range(0, 7), $urandom_range(0, 7), random_elem());
          send_request(r, 1'b0, '0);
          if (r.cmd != CMD_UNUSED) random_items++;
        end
        // Refresh a few entries the compute reads so some products see new data.
        if (m != 0 && n != 0) begin
          repeat ($urandom_range(0, 6)) begin
            ri = $urandom_range(0, m - 1);
            rc = $urandom_range(0, n - 1);
            send_request(make_request(CMD_WRITE_A, ri, rc, random_elem()), 1'b0, '0);
            random_items++;
          end
        end
        if (n != 0 && k != 0) begin
          repeat ($urandom_range(0, 6)) begin
            ri = $urandom_range(0, n - 1);
            rc = $urandom_range(0, k - 1);
            send_request(make_request(CMD_WRITE_B, ri, rc, random_elem()), 1'b0, '0);
            random_items++;
          end
        end
        // Load every entry the compute will read that has never been written.
        for (int i = 0; i < m; i++)
          for (int p = 0; p < n; p++)
            if (!a_written[i][p]) begin
              send_request(make_request(CMD_WRITE_A, i, p, random_elem()), 1'b0, '0);
              random_items++;
            end
        for (int p = 0; p < n; p++)
          for (int j = 0; j < k; j++)
            if (!b_written[p][j]) begin
              send_request(make_request(CMD_WRITE_B, p, j, random_elem()), 1'b0, '0);
              random_items++;
            end
        // In phase four, hold each compute until every owed C element is in.
        if (phase == 4) settle();
        send_request(make_request(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                                  random_elem()), 1'b0, '0);
        random_items++;
      end
      phase++;
    end

    settle();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0 && c_elem_queue.size() == 0)
      $display("matrix_multiply_engine: match");
    else
      $display("matrix_multiply_engine: mismatch");
    $finish;
  end

  // Receiver: randomly chosen stall modes, plus a long hold-off on request
  // from the stimulus so the engine fills and stalls input.
  initial begin
    int unsigned stall_mode, mode_left;
    stall_mode = 0;
    mode_left  = 0;
    hold_seen  = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        case (stall_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= (mode_left % 5 == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Check each accepted C element against the oldest one owed.
  always @(posedge clk) begin
    c_elem_t got;
    c_elem_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.row  = m_tdata[IDX_W-1:0];
      got.col  = m_tdata[2*IDX_W-1:IDX_W];
      got.dot  = m_tdata[2*IDX_W+SUM_W-1:2*IDX_W];
      got.last = m_tlast;
      if (c_elem_queue.size() == 0) begin
        report_mismatch("not owed", '0, got);
      end else begin
        want = c_elem_queue.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.dot !== want.dot ||
            got.last !== want.last)
          report_mismatch("differs", want, got);
      end
    end
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("matrix_multiply_engine: mismatch");
    $finish;
  end

endmodule
